@@ sv/mac_learning_table_with_aging_assert.svh @@
// assertion macros for the mac learning table
// used by the top level only, no other dependencies
`ifndef MAC_LEARNING_TABLE_WITH_AGING_ASSERT_SVH
`define MAC_LEARNING_TABLE_WITH_AGING_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define MLT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("mlt check failed");
`define MLT_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("mlt check failed");
`else
`define MLT_ASSERT(lbl, prop)
`define MLT_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

@@ sv/mlt_pkg.sv @@
// shared constants and controller/datapath interface types
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package mlt_pkg;
  localparam int DEFAULT_DEPTH = 256;
  localparam logic [15:0] MAX_AGE_RST = 16'd300;
  localparam logic [7:0] AGING_RST = 8'd5;
  localparam int ENTRY_W = 48 + 64 + 16 + 32;
  localparam logic REG_MAX_AGE = 1'b0;
  localparam logic REG_AGING = 1'b1;
  localparam logic OP_PACKET = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic load_pkt;
    logic tick;
    logic scan_start;
    logic scan_run;
    logic sweep_mode;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic sweep_due;
  } sts_t;
endpackage
`default_nettype wire

@@ sv/mac_learning_table_with_aging.sv @@
// Layer-2 learning table with aging. A transaction is accepted when start is high
// and busy is low. An Ethernet packet scans the entry ram one entry per clock;
// done pulses for one cycle with the decision as busy drops, so a new packet is
// accepted only after the last one is through; the single-port read of the table
// sets that pace. A tick that starts an aging sweep holds busy until the sweep
// ends; other ticks and non-Ethernet packets leave busy low, and non-Ethernet
// packets give no result. The receiver cannot stall; results must be taken in
// the cycle done is high.
// depends on mlt_pkg, mlt_ctrl, mlt_datapath, mlt_ram
`timescale 1ns / 1ps
`default_nettype none
`include "mac_learning_table_with_aging_assert.svh"
module mac_learning_table_with_aging #(
  parameter int TABLE_DEPTH = mlt_pkg::DEFAULT_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        op,
  input  wire logic        is_ethernet,
  input  wire logic [63:0] switch_id,
  input  wire logic [47:0] src_mac,
  input  wire logic [47:0] dst_mac,
  input  wire logic [15:0] in_port,
  output logic             done,
  output logic             action,
  output logic [15:0]      out_port,
  output logic             install_flow,
  output logic             learn_dropped,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  logic [15:0] max_age;
  logic [7:0]  sweep_period;
  mlt_pkg::cmd_t cmd;
  mlt_pkg::sts_t sts;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == mlt_pkg::REG_AGING) ? {24'd0, sweep_period}
                                                  : {16'd0, max_age};

  always_ff @(posedge clk) begin
    if (rst) begin
      max_age <= mlt_pkg::MAX_AGE_RST;
      sweep_period <= mlt_pkg::AGING_RST;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == mlt_pkg::REG_MAX_AGE) begin
        max_age <= pwdata[15:0];
      end else begin
        sweep_period <= pwdata[7:0];
      end
    end
  end

  mlt_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .op         (op),
    .is_ethernet(is_ethernet),
    .sts        (sts),
    .cmd        (cmd),
    .busy       (busy)
  );

  mlt_datapath #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .switch_id     (switch_id),
    .src_mac       (src_mac),
    .dst_mac       (dst_mac),
    .in_port       (in_port),
    .max_age       (max_age),
    .sweep_period  (sweep_period),
    .done          (done),
    .action        (action),
    .out_port      (out_port),
    .install_flow  (install_flow),
    .learn_dropped (learn_dropped)
  );

  `MLT_ASSERT(a_done_after_busy, done |-> !busy && $past(busy))
  `MLT_ASSERT(a_busy_from_start, $rose(busy) |-> $past(start))
  `MLT_ASSERT(a_flood_no_port, done && !action |-> out_port == 16'd0 && !install_flow)
  `MLT_ASSERT_ALWAYS(a_reset_idle, rst |=> !busy && !done)
endmodule
`default_nettype wire

@@ sv/mlt_ram.sv @@
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module mlt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [AW-1:0]        waddr,
  input  wire logic [WIDTH-1:0]     wdata,
  input  wire logic [AW-1:0]        raddr,
  output logic      [WIDTH-1:0]     rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ sv/mlt_datapath.sv @@
// table datapath: entry ram, valid bits, scan pipeline, clock and result registers
// depends on mlt_pkg and mlt_ram
`timescale 1ns / 1ps
`default_nettype none
module mlt_datapath #(
  parameter int TABLE_DEPTH = mlt_pkg::DEFAULT_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire mlt_pkg::cmd_t cmd,
  output mlt_pkg::sts_t      sts,
  input  wire logic [63:0]   switch_id,
  input  wire logic [47:0]   src_mac,
  input  wire logic [47:0]   dst_mac,
  input  wire logic [15:0]   in_port,
  input  wire logic [15:0]   max_age,
  input  wire logic [7:0]    sweep_period,
  output logic               done,
  output logic               action,
  output logic [15:0]        out_port,
  output logic               install_flow,
  output logic               learn_dropped
);
  localparam int IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CntW = $clog2(TABLE_DEPTH + 1) + 1;
  localparam logic [CntW-1:0] LastCnt = CntW'(TABLE_DEPTH);

  // transaction registers
  logic [63:0] k_sw;
  logic [47:0] k_src;
  logic [47:0] k_dst;
  logic [15:0] k_port;

  logic [31:0] now_seconds;
  logic [7:0]  sweep_count;
  logic [7:0]  sweep_count_next;
  logic [31:0] age_base;

  logic [TABLE_DEPTH-1:0] entry_valid;
  logic [CntW-1:0] cnt;
  logic            chk_vld;
  logic [IdxW-1:0] chk_idx;

  logic            src_hit;
  logic [IdxW-1:0] src_idx;
  logic            free_found;
  logic [IdxW-1:0] free_idx;
  logic            dst_hit;
  logic [15:0]     dst_port;

  logic [mlt_pkg::ENTRY_W-1:0] rdata;
  logic [mlt_pkg::ENTRY_W-1:0] wdata;
  logic            we;
  logic [IdxW-1:0] waddr;
  logic [47:0] r_mac;
  logic [63:0] r_sw;
  logic [15:0] r_port;
  logic [31:0] r_stamp;
  logic [31:0] age_diff;
  logic        cur_valid;
  logic        learned;
  logic        same_key;

  assign {r_mac, r_sw, r_port, r_stamp} = rdata;
  assign cur_valid = entry_valid[chk_idx];
  assign age_diff = age_base - r_stamp;
  assign learned = src_hit | free_found;
  assign same_key = (k_src == k_dst);
  assign we = cmd.commit & learned;
  assign waddr = src_hit ? src_idx : free_idx;
  assign wdata = {k_src, k_sw, k_port, now_seconds};
  assign sweep_count_next = sweep_count + 8'd1;

  assign sts.scan_done = (cnt == LastCnt) & ~chk_vld;
  assign sts.sweep_due = (sweep_count_next >= sweep_period);

  mlt_ram #(
    .WIDTH(mlt_pkg::ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(cnt[IdxW-1:0]),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_pkt) begin
      k_sw <= switch_id;
      k_src <= src_mac;
      k_dst <= dst_mac;
      k_port <= in_port;
    end
    if (cmd.tick) begin
      // sweep compares against the already advanced time
      age_base <= now_seconds + 32'd1 - {16'd0, max_age};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now_seconds <= '0;
      sweep_count <= '0;
      entry_valid <= '0;
      cnt <= LastCnt;
      chk_vld <= 1'b0;
      chk_idx <= '0;
      src_hit <= 1'b0;
      src_idx <= '0;
      free_found <= 1'b0;
      free_idx <= '0;
      dst_hit <= 1'b0;
      dst_port <= '0;
      done <= 1'b0;
      action <= 1'b0;
      out_port <= '0;
      install_flow <= 1'b0;
      learn_dropped <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.tick) begin
        now_seconds <= now_seconds + 32'd1;
        sweep_count <= sts.sweep_due ? 8'd0 : sweep_count_next;
      end
      if (cmd.scan_start) begin
        cnt <= '0;
        chk_vld <= 1'b0;
        src_hit <= 1'b0;
        free_found <= 1'b0;
        dst_hit <= 1'b0;
      end else if (cmd.scan_run) begin
        if (cnt != LastCnt) begin
          chk_vld <= 1'b1;
          chk_idx <= cnt[IdxW-1:0];
          cnt <= cnt + CntW'(1);
        end else begin
          chk_vld <= 1'b0;
        end
        if (chk_vld) begin
          if (cmd.sweep_mode) begin
            if (cur_valid && age_diff != 32'd0 && !age_diff[31]) begin
              entry_valid[chk_idx] <= 1'b0;
            end
          end else begin
            if (cur_valid && r_sw == k_sw && r_mac == k_src) begin
              src_hit <= 1'b1;
              src_idx <= chk_idx;
            end
            if (cur_valid && r_sw == k_sw && r_mac == k_dst) begin
              dst_hit <= 1'b1;
              dst_port <= r_port;
            end
            if (!cur_valid && !free_found) begin
              free_found <= 1'b1;
              free_idx <= chk_idx;
            end
          end
        end
      end
      if (cmd.commit) begin
        if (learned) begin
          entry_valid[waddr] <= 1'b1;
        end
        // a source equal to the destination hits the entry just learned
        done <= 1'b1;
        action <= same_key ? learned : dst_hit;
        install_flow <= same_key ? learned : dst_hit;
        out_port <= same_key ? (learned ? k_port : 16'd0) : (dst_hit ? dst_port : 16'd0);
        learn_dropped <= ~learned;
      end
    end
  end
endmodule
`default_nettype wire

@@ sv/mlt_ctrl.sv @@
// controller state machine sequencing packet scans and aging sweeps
// depends on mlt_pkg
`timescale 1ns / 1ps
`default_nettype none
module mlt_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic          op,
  input  wire logic          is_ethernet,
  input  wire mlt_pkg::sts_t sts,
  output mlt_pkg::cmd_t      cmd,
  output logic               busy
);
  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_COMMIT, S_SWEEP} state_t;
  state_t state;
  logic accept;

  assign accept = start & ~busy;

  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (accept && op == mlt_pkg::OP_TICK) begin
          cmd.tick = 1'b1;
          cmd.scan_start = sts.sweep_due;
        end else if (accept && is_ethernet) begin
          cmd.load_pkt = 1'b1;
          cmd.scan_start = 1'b1;
        end
      end
      S_SCAN: cmd.scan_run = 1'b1;
      S_COMMIT: cmd.commit = 1'b1;
      S_SWEEP: begin
        cmd.scan_run = 1'b1;
        cmd.sweep_mode = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept && op == mlt_pkg::OP_TICK && sts.sweep_due) begin
            state <= S_SWEEP;
            busy <= 1'b1;
          end else if (accept && op == mlt_pkg::OP_PACKET && is_ethernet) begin
            state <= S_SCAN;
            busy <= 1'b1;
          end
        end
        S_SCAN: begin
          if (sts.scan_done) begin
            state <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          state <= S_IDLE;
          busy <= 1'b0;
        end
        S_SWEEP: begin
          if (sts.scan_done) begin
            state <= S_IDLE;
            busy <= 1'b0;
          end
        end
        default: begin
          state <= S_IDLE;
          busy <= 1'b0;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

@@ test/mac_learning_table_with_aging_tb.sv @@
// testbench for the mac learning table: directed and random packets and ticks,
// several register settings, results checked against a behavioral table model
// depends on mlt_pkg and mac_learning_table_with_aging
`timescale 1ns / 1ps

module mac_learning_table_with_aging_tb;

  localparam int DEPTH = mlt_pkg::DEFAULT_DEPTH;
  localparam int SETTLE = DEPTH + 40;

  typedef struct {
    logic        op;
    logic        eth;
    logic [63:0] sw;
    logic [47:0] src;
    logic [47:0] dst;
    logic [15:0] port;
  } frame_t;

  typedef struct {
    logic        action;
    logic [15:0] out_port;
    logic        install;
    logic        dropped;
  } decision_t;

  class bridge_scoreboard;
    bit          slot_valid[DEPTH];
    logic [47:0] slot_mac[DEPTH];
    logic [63:0] slot_sw[DEPTH];
    logic [15:0] slot_port[DEPTH];
    logic [31:0] slot_stamp[DEPTH];
    logic [31:0] now_sec;
    logic [7:0]  tick_count;
    logic [15:0] max_age;
    logic [7:0]  sweep_period;
    decision_t   pending_q[$];
    int          errors;

    function new();
      for (int i = 0; i < DEPTH; i++) slot_valid[i] = 0;
      now_sec = 0;
      tick_count = 0;
      max_age = mlt_pkg::MAX_AGE_RST;
      sweep_period = mlt_pkg::AGING_RST;
      errors = 0;
    endfunction

    function int lookup(logic [47:0] mac, logic [63:0] sw);
      for (int i = 0; i < DEPTH; i++)
        if (slot_valid[i] && slot_mac[i] == mac && slot_sw[i] == sw) return i;
      return -1;
    endfunction

    function void set_reg(logic idx, logic [31:0] val);
      if (idx == mlt_pkg::REG_MAX_AGE) max_age = val[15:0];
      else sweep_period = val[7:0];
    endfunction

    // note an accepted transaction and queue the decision it causes
    function void note_frame(frame_t f);
      int idx;
      logic [31:0] diff;
      decision_t d;
      if (f.op == mlt_pkg::OP_TICK) begin
        now_sec = now_sec + 32'd1;
        tick_count = tick_count + 8'd1;
        if (tick_count >= sweep_period) begin
          tick_count = 0;
          for (int i = 0; i < DEPTH; i++) begin
            diff = now_sec - (slot_stamp[i] + {16'd0, max_age});
            // wrap-safe stamp + max_age < now
            if (slot_valid[i] && diff != 0 && !diff[31]) slot_valid[i] = 0;
          end
        end
        return;
      end
      if (!f.eth) return;
      d.dropped = 0;
      idx = lookup(f.src, f.sw);
      if (idx < 0) begin
        for (int i = 0; i < DEPTH; i++)
          if (!slot_valid[i]) begin
            idx = i;
            break;
          end
        if (idx >= 0) begin
          slot_valid[idx] = 1;
          slot_mac[idx] = f.src;
          slot_sw[idx] = f.sw;
        end
      end
      if (idx >= 0) begin
        slot_port[idx] = f.port;
        slot_stamp[idx] = now_sec;
      end else begin
        d.dropped = 1;
      end
      idx = lookup(f.dst, f.sw);
      d.action = (idx >= 0);
      d.out_port = (idx >= 0) ? slot_port[idx] : 16'd0;
      d.install = (idx >= 0);
      pending_q.push_back(d);
    endfunction

    function void check_decision(decision_t got);
      decision_t exp_d;
      if (pending_q.size() == 0) begin
        $error("unexpected result: action %0d out_port %0d", got.action, got.out_port);
        errors++;
        return;
      end
      exp_d = pending_q.pop_front();
      if (got.action !== exp_d.action) begin
        $error("action: expected %0d actual %0d", exp_d.action, got.action);
        errors++;
      end
      if (got.out_port !== exp_d.out_port) begin
        $error("out_port: expected %0d actual %0d", exp_d.out_port, got.out_port);
        errors++;
      end
      if (got.install !== exp_d.install) begin
        $error("install_flow: expected %0d actual %0d", exp_d.install, got.install);
        errors++;
      end
      if (got.dropped !== exp_d.dropped) begin
        $error("learn_dropped: expected %0d actual %0d", exp_d.dropped, got.dropped);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic        busy;
  logic        op = 0;
  logic        is_ethernet = 0;
  logic [63:0] switch_id = 0;
  logic [47:0] src_mac = 0;
  logic [47:0] dst_mac = 0;
  logic [15:0] in_port = 0;
  logic        done;
  logic        action;
  logic [15:0] out_port;
  logic        install_flow;
  logic        learn_dropped;
  logic        psel = 0;
  logic        penable = 0;
  logic        pwrite = 0;
  logic [2:0]  paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic        pready;

  bridge_scoreboard sb = new();
  bit quiet_stretch = 0;
  logic [47:0] mac_pool[16];
  logic [63:0] sw_pool[3];

  mac_learning_table_with_aging u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .is_ethernet(is_ethernet), .switch_id(switch_id), .src_mac(src_mac),
    .dst_mac(dst_mac), .in_port(in_port), .done(done), .action(action),
    .out_port(out_port), .install_flow(install_flow), .learn_dropped(learn_dropped),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    decision_t got;
    if (!rst && done) begin
      got.action = action;
      got.out_port = out_port;
      got.install = install_flow;
      got.dropped = learn_dropped;
      sb.check_decision(got);
    end
  end

  task automatic send_frame(frame_t f);
    if (!quiet_stretch && $urandom_range(99) < 12) begin
      start <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    op <= f.op;
    is_ethernet <= f.eth;
    switch_id <= f.sw;
    src_mac <= f.src;
    dst_mac <= f.dst;
    in_port <= f.port;
    start <= 1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_frame(f);
  endtask

  task automatic send_tick();
    frame_t f;
    f.op = mlt_pkg::OP_TICK;
    f.eth = 1'($urandom_range(1));
    f.sw = {$urandom, $urandom};
    f.src = 48'({$urandom, $urandom});
    f.dst = 48'({$urandom, $urandom});
    f.port = 16'($urandom);
    send_frame(f);
  endtask

  task automatic send_pkt(logic eth, logic [63:0] sw, logic [47:0] src,
                          logic [47:0] dst, logic [15:0] port);
    frame_t f;
    f.op = mlt_pkg::OP_PACKET;
    f.eth = eth;
    f.sw = sw;
    f.src = src;
    f.dst = dst;
    f.port = port;
    send_frame(f);
  endtask

  // let the block finish all work before touching registers
  task automatic drain();
    start <= 0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    sb.set_reg(idx, val);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    @(posedge clk);
  endtask

  task automatic random_frame();
    int r;
    r = $urandom_range(99);
    if (r < 18) send_tick();
    else if (r < 24)
      send_pkt(1'b0, {$urandom, $urandom}, 48'({$urandom, $urandom}),
               48'({$urandom, $urandom}), 16'($urandom));
    else if (r < 34)
      send_pkt(1'b1, {$urandom, $urandom}, 48'({$urandom, $urandom}),
               48'({$urandom, $urandom}), 16'($urandom));
    else
      send_pkt(1'b1, sw_pool[$urandom_range(2)], mac_pool[$urandom_range(15)],
               mac_pool[$urandom_range(15)], 16'($urandom));
  endtask

  initial begin
    logic [15:0] age_pick[6] = '{16'd0, 16'd1, 16'd3, 16'd12, 16'hffff, 16'd7};
    logic [7:0]  ivl_pick[6] = '{8'd1, 8'd0, 8'd2, 8'd255, 8'd3, 8'd1};
    for (int i = 0; i < 16; i++) mac_pool[i] = 48'({$urandom, $urandom});
    mac_pool[0] = 48'h0;
    mac_pool[1] = 48'hffff_ffff_ffff;
    sw_pool[0] = 64'h0;
    sw_pool[1] = 64'hffff_ffff_ffff_ffff;
    sw_pool[2] = {$urandom, $urandom};
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes, non-ethernet, src equal dst, hits, ticks and a sweep
    send_pkt(0, 64'h5, 48'h1, 48'h1, 16'h1);
    send_pkt(1, 64'h0, 48'h0, 48'hffff_ffff_ffff, 16'h0);
    send_pkt(1, 64'h0, 48'hffff_ffff_ffff, 48'h0, 16'hffff);
    send_pkt(1, 64'hffff_ffff_ffff_ffff, 48'h0, 48'h0, 16'ha5a5);
    send_pkt(1, 64'h0, 48'h123456789abc, 48'h123456789abc, 16'h5a5a);
    send_pkt(1, 64'hffff_ffff_ffff_ffff, 48'h0, 48'hffff_ffff_ffff, 16'h7);
    send_pkt(1, 64'h0, 48'h0, 48'h123456789abc, 16'h3);
    repeat (6) send_tick();
    send_pkt(1, 64'h0, 48'h42, 48'hffff_ffff_ffff, 16'h9);
    drain();

    // register extremes: immediate aging with a sweep every tick
    write_reg(mlt_pkg::REG_MAX_AGE, 32'd0);
    write_reg(mlt_pkg::REG_AGING, 32'd1);
    send_pkt(1, 64'h1, 48'haa, 48'hbb, 16'd10);
    send_pkt(1, 64'h1, 48'hbb, 48'haa, 16'd11);
    send_tick();
    send_pkt(1, 64'h1, 48'hcc, 48'haa, 16'd12);
    send_tick();
    send_tick();
    send_pkt(1, 64'h1, 48'hdd, 48'hbb, 16'd13);
    drain();

    // fill the table until new sources are dropped
    write_reg(mlt_pkg::REG_MAX_AGE, 32'hffff);
    write_reg(mlt_pkg::REG_AGING, 32'hff);
    quiet_stretch = 1;
    for (int i = 0; i < DEPTH + 20; i++)
      send_pkt(1, 64'h77, {16'hbeef, 32'(i)}, {16'hbeef, 32'($urandom_range(DEPTH + 30))},
               16'($urandom));
    quiet_stretch = 0;
    drain();
    // clear everything by aging out
    write_reg(mlt_pkg::REG_MAX_AGE, 32'd0);
    write_reg(mlt_pkg::REG_AGING, 32'd0);
    send_tick();
    send_tick();
    send_pkt(1, 64'h77, 48'h1, {16'hbeef, 32'd3}, 16'd1);
    drain();

    // random phases, each with its own register setting
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(mlt_pkg::REG_MAX_AGE, (ph == 5) ? $urandom_range(65535) : age_pick[ph]);
      write_reg(mlt_pkg::REG_AGING, (ph == 4) ? $urandom_range(255) : ivl_pick[ph]);
      quiet_stretch = (ph == 2);
      repeat (110) random_frame();
      drain();
    end

    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("status: fail");
    $finish;
  end
endmodule
